@@ rtl/vcs_pkg.sv @@
// Shared types, constants and the control program for the cosine similarity block.
// No dependencies; every other file but vcs_checker imports this package.
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int ELEM_W   = 16;                  // element width, Q8.8
  localparam int MAX_LEN  = 4096;                // pairs accumulated per vector
  localparam int CNT_W    = $clog2(MAX_LEN + 2);  // counts up to MAX_LEN+1
  localparam int DOT_W    = 45;
  localparam int NORM_W   = 44;
  localparam int CH_W     = (DOT_W + 1) / 2;     // chunk width for wide products
  localparam int MUL_W    = CH_W + 1;            // signed multiplier operand
  localparam int PROD_W   = 2 * MUL_W;
  localparam int NA_HI_W  = NORM_W - CH_W;
  localparam int DM_HI_W  = DOT_W - CH_W;
  localparam int WIDE_W   = 2 * DOT_W;           // wide product accumulator
  localparam int P_W      = 2 * NORM_W;          // norm_a * norm_b
  localparam int COS_W    = 16;
  localparam int FRAC_W   = COS_W - 1;
  localparam int M_W      = FRAC_W + 1;          // magnitude 0..2^FRAC_W
  localparam int K_W      = $clog2(M_W);
  localparam int R_W      = WIDE_W + 2 * FRAC_W; // dot^2 * 2^(2*FRAC_W)
  localparam int S_W      = R_W + 2;
  localparam int MP_W     = M_W + P_W;
  localparam int PC_W     = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OPD_IN_A, OPD_IN_B, OPD_A, OPD_B,
    OPD_NA_LO, OPD_NA_HI, OPD_NB_LO, OPD_NB_HI,
    OPD_DM_LO, OPD_DM_HI
  } opd_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_DOT, ACC_NA, ACC_NB, ACC_WIDE
  } acc_t;

  typedef enum logic [1:0] {
    SH_0, SH_1CH, SH_2CH
  } wsh_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_PREP, OP_SAVE_P, OP_INIT, OP_TRIAL, OP_DECIDE, OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_WAIT_IN, C_IF_NLAST, C_LOOP_K, C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    logic   mul_en;
    opd_t   mul_a;
    opd_t   mul_b;
    acc_t   acc;
    wsh_t   sh;
    dp_op_t op;
    cond_t  cond;
    pc_t    target;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic last;
    logic k_zero;
    logic out_free;
  } stat_t;

  // Step numbers the program jumps to
  localparam pc_t PC_IDLE   = 5'd0;
  localparam pc_t PC_FINAL  = 5'd3;
  localparam pc_t PC_TRIAL  = 5'd16;

  // Control program: one word per step.
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{mul_en: 1'b0, mul_a: OPD_A, mul_b: OPD_B, acc: ACC_NONE, sh: SH_0,
          op: OP_NOP, cond: C_NEXT, target: PC_IDLE};
    case (pc)
      5'd0: begin
        w.mul_en = 1'b1; w.mul_a = OPD_IN_A; w.mul_b = OPD_IN_B;
        w.acc = ACC_NB; w.cond = C_WAIT_IN; w.target = PC_FINAL;
      end
      5'd1: begin
        w.mul_en = 1'b1; w.mul_a = OPD_A; w.mul_b = OPD_A; w.acc = ACC_DOT;
      end
      5'd2: begin
        w.mul_en = 1'b1; w.mul_a = OPD_B; w.mul_b = OPD_B; w.acc = ACC_NA;
        w.cond = C_IF_NLAST; w.target = PC_IDLE;
      end
      5'd3: begin
        w.acc = ACC_NB; w.op = OP_PREP;
      end
      5'd4: begin
        w.mul_en = 1'b1; w.mul_a = OPD_NA_LO; w.mul_b = OPD_NB_LO;
      end
      5'd5: begin
        w.mul_en = 1'b1; w.mul_a = OPD_NA_LO; w.mul_b = OPD_NB_HI;
        w.acc = ACC_WIDE; w.sh = SH_0;
      end
      5'd6: begin
        w.mul_en = 1'b1; w.mul_a = OPD_NA_HI; w.mul_b = OPD_NB_LO;
        w.acc = ACC_WIDE; w.sh = SH_1CH;
      end
      5'd7: begin
        w.mul_en = 1'b1; w.mul_a = OPD_NA_HI; w.mul_b = OPD_NB_HI;
        w.acc = ACC_WIDE; w.sh = SH_1CH;
      end
      5'd8: begin
        w.acc = ACC_WIDE; w.sh = SH_2CH;
      end
      5'd9: begin
        w.op = OP_SAVE_P;
      end
      5'd10: begin
        w.mul_en = 1'b1; w.mul_a = OPD_DM_LO; w.mul_b = OPD_DM_LO;
      end
      5'd11: begin
        w.mul_en = 1'b1; w.mul_a = OPD_DM_LO; w.mul_b = OPD_DM_HI;
        w.acc = ACC_WIDE; w.sh = SH_0;
      end
      5'd12: begin
        w.mul_en = 1'b1; w.mul_a = OPD_DM_HI; w.mul_b = OPD_DM_LO;
        w.acc = ACC_WIDE; w.sh = SH_1CH;
      end
      5'd13: begin
        w.mul_en = 1'b1; w.mul_a = OPD_DM_HI; w.mul_b = OPD_DM_HI;
        w.acc = ACC_WIDE; w.sh = SH_1CH;
      end
      5'd14: begin
        w.acc = ACC_WIDE; w.sh = SH_2CH;
      end
      5'd15: begin
        w.op = OP_INIT;
      end
      5'd16: begin
        w.op = OP_TRIAL;
      end
      5'd17: begin
        w.op = OP_DECIDE; w.cond = C_LOOP_K; w.target = PC_TRIAL;
      end
      5'd18: begin
        w.op = OP_FINISH; w.cond = C_WAIT_OUT; w.target = PC_IDLE;
      end
      default: begin
        w.cond = C_JUMP; w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/vcs_sequencer.sv @@
// Step counter and jump logic; reads control words from the program in vcs_pkg.
// Depends on vcs_pkg.
`timescale 1ns / 1ps

module vcs_sequencer
  import vcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_tlast,
  input  stat_t stat,
  output logic  in_tready,
  output logic  in_take,
  output ctrl_t ctrl
);

  pc_t pc_r, pc_nxt;

  // Control word of the current step
  always_comb begin
    ctrl      = ucode(pc_r);
    in_tready = (ctrl.cond == C_WAIT_IN);
    in_take   = in_tready & in_tvalid;
  end

  // Next step
  always_comb begin
    pc_nxt = pc_r + pc_t'(1);
    case (ctrl.cond)
      C_NEXT:     pc_nxt = pc_r + pc_t'(1);
      C_JUMP:     pc_nxt = ctrl.target;
      C_WAIT_IN: begin
        if (!in_take) begin
          pc_nxt = pc_r;
        end else if (!stat.full) begin
          pc_nxt = pc_r + pc_t'(1);
        end else if (in_tlast) begin
          pc_nxt = ctrl.target;
        end else begin
          pc_nxt = pc_r;
        end
      end
      C_IF_NLAST: pc_nxt = stat.last ? pc_r + pc_t'(1) : ctrl.target;
      C_LOOP_K:   pc_nxt = stat.k_zero ? pc_r + pc_t'(1) : ctrl.target;
      C_WAIT_OUT: pc_nxt = stat.out_free ? ctrl.target : pc_r;
      default:    pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/vcs_datapath.sv @@
// Datapath: shared multiplier, accumulators, wide products and the root-free
// magnitude search, plus the result register. Depends on vcs_pkg.
`timescale 1ns / 1ps

module vcs_datapath
  import vcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctrl,
  input  logic                     in_take,
  input  logic signed [ELEM_W-1:0] in_elem_a,
  input  logic signed [ELEM_W-1:0] in_elem_b,
  input  logic                     in_last,
  input  logic                     out_tready,
  output logic                     out_valid,
  output logic        [COS_W-1:0]  cosine_value,
  output logic                     zero_norm,
  output logic                     length_overflow,
  output stat_t                    stat
);

  logic signed [ELEM_W-1:0] a_r, b_r;
  logic                     last_r;
  logic        [CNT_W-1:0]  cnt_r;
  logic        [DOT_W-1:0]  dot_r;
  logic        [NORM_W-1:0] na_r, nb_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     pvld_r;
  logic        [DOT_W-1:0]  dm_r;
  logic                     dneg_r;
  logic        [WIDE_W-1:0] wide_r;
  logic        [P_W-1:0]    p_r;
  logic        [R_W-1:0]    r_r;
  logic        [S_W-1:0]    s_r, t_r, cand;
  logic        [MP_W-1:0]   mp_r;
  logic        [M_W-1:0]    m_r;
  logic        [K_W-1:0]    k_r;
  logic        [COS_W-1:0]  cos_r, cos_nxt;
  logic                     zn_r, ovf_r, oval_r;

  logic signed [MUL_W-1:0]  opa, opb;
  logic                     full, take_new, issue, fire, trial_ok, zn_now;
  logic        [WIDE_W-1:0] wadd;

  function automatic logic signed [MUL_W-1:0] pick(
    input opd_t sel,
    input logic signed [ELEM_W-1:0] ia, ib, ra, rb,
    input logic [NORM_W-1:0] na, nb,
    input logic [DOT_W-1:0] dm
  );
    logic signed [MUL_W-1:0] v;
    case (sel)
      OPD_IN_A:  v = MUL_W'(ia);
      OPD_IN_B:  v = MUL_W'(ib);
      OPD_A:     v = MUL_W'(ra);
      OPD_B:     v = MUL_W'(rb);
      OPD_NA_LO: v = $signed(MUL_W'(na[CH_W-1:0]));
      OPD_NA_HI: v = $signed(MUL_W'(na[NORM_W-1:CH_W]));
      OPD_NB_LO: v = $signed(MUL_W'(nb[CH_W-1:0]));
      OPD_NB_HI: v = $signed(MUL_W'(nb[NORM_W-1:CH_W]));
      OPD_DM_LO: v = $signed(MUL_W'(dm[CH_W-1:0]));
      OPD_DM_HI: v = $signed(MUL_W'(dm[DOT_W-1:CH_W]));
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    full     = (cnt_r >= CNT_W'(MAX_LEN));
    take_new = in_take & ~full;
    issue    = ctrl.mul_en & ((ctrl.cond != C_WAIT_IN) | take_new);
    opa      = pick(ctrl.mul_a, in_elem_a, in_elem_b, a_r, b_r, na_r, nb_r, dm_r);
    opb      = pick(ctrl.mul_b, in_elem_a, in_elem_b, a_r, b_r, na_r, nb_r, dm_r);
    prod_nxt = opa * opb;
    fire     = (ctrl.op == OP_FINISH) & (~oval_r | out_tready);
    zn_now   = (na_r == '0) | (nb_r == '0);
    case (ctrl.sh)
      SH_0:    wadd = WIDE_W'(prod_r[2*CH_W-1:0]);
      SH_1CH:  wadd = WIDE_W'(prod_r[2*CH_W-1:0]) << CH_W;
      SH_2CH:  wadd = WIDE_W'(prod_r[2*CH_W-1:0]) << (2 * CH_W);
      default: wadd = '0;
    endcase
    cand     = s_r + t_r;
    trial_ok = (cand <= S_W'(r_r)) & ~m_r[M_W-1];
    if (zn_now) begin
      cos_nxt = '0;
    end else if (dneg_r) begin
      cos_nxt = COS_W'(-m_r);
    end else if (m_r[M_W-1]) begin
      cos_nxt = {1'b0, {FRAC_W{1'b1}}};
    end else begin
      cos_nxt = COS_W'(m_r);
    end
  end

  // Product register and control of accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      cnt_r  <= '0;
      dot_r  <= '0;
      na_r   <= '0;
      nb_r   <= '0;
      oval_r <= 1'b0;
    end else begin
      pvld_r <= issue;
      if (in_take) begin
        cnt_r <= full ? CNT_W'(MAX_LEN + 1) : cnt_r + CNT_W'(1);
      end
      if (pvld_r && ctrl.acc == ACC_DOT) begin
        dot_r <= dot_r + prod_r[DOT_W-1:0];
      end
      if (pvld_r && ctrl.acc == ACC_NA) begin
        na_r <= na_r + prod_r[NORM_W-1:0];
      end
      if (pvld_r && ctrl.acc == ACC_NB) begin
        nb_r <= nb_r + prod_r[NORM_W-1:0];
      end
      if (fire) begin
        cnt_r <= '0;
        dot_r <= '0;
        na_r  <= '0;
        nb_r  <= '0;
      end
      if (fire) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_take) begin
      a_r    <= in_elem_a;
      b_r    <= in_elem_b;
      last_r <= in_last;
    end
    if (ctrl.acc == ACC_WIDE && pvld_r) begin
      wide_r <= wide_r + wadd;
    end
    case (ctrl.op)
      OP_PREP: begin
        dneg_r <= dot_r[DOT_W-1];
        dm_r   <= dot_r[DOT_W-1] ? -dot_r : dot_r;
        wide_r <= '0;
      end
      OP_SAVE_P: begin
        p_r    <= wide_r[P_W-1:0];
        wide_r <= '0;
      end
      OP_INIT: begin
        r_r  <= R_W'(wide_r) << (2 * FRAC_W);
        s_r  <= '0;
        mp_r <= '0;
        m_r  <= '0;
        k_r  <= K_W'(M_W - 1);
      end
      OP_TRIAL: begin
        // (m + 2^k)^2 P - m^2 P = m P 2^(k+1) + P 2^(2k)
        t_r <= (S_W'(mp_r) << ({1'b0, k_r} + (K_W + 1)'(1)))
             + (S_W'(p_r) << {k_r, 1'b0});
      end
      OP_DECIDE: begin
        if (trial_ok) begin
          s_r  <= cand;
          mp_r <= mp_r + (MP_W'(p_r) << k_r);
          m_r  <= m_r | (M_W'(1) << k_r);
        end
        k_r <= k_r - K_W'(1);
      end
      default: ;
    endcase
    if (fire) begin
      cos_r <= cos_nxt;
      zn_r  <= zn_now;
      ovf_r <= (cnt_r > CNT_W'(MAX_LEN));
    end
  end

  assign out_valid       = oval_r;
  assign cosine_value    = cos_r;
  assign zero_norm       = zn_r;
  assign length_overflow = ovf_r;
  assign stat            = '{full: full, last: last_r, k_zero: (k_r == '0),
                             out_free: (~oval_r | out_tready)};

endmodule

@@ rtl/vector_cosine_similarity.sv @@
// Top level of the streaming cosine similarity block.
// Depends on vcs_pkg, vcs_sequencer and vcs_datapath.
`timescale 1ns / 1ps

// Streams two vectors as element pairs (signed Q8.8) and returns one request per
// vector pair: cosine similarity in signed Q1.15, truncated toward zero and
// saturated, so an exact +1.0 reads 32767. For each accepted pair
// the one shared 24x24 multiplier forms a*b, a*a and b*b in turn, and the
// control program steps through them. After the pair marked tlast the block
// forms norm_a*norm_b and dot^2 from 23-bit chunks on the same multiplier and
// runs a 16-step bit-serial search for the largest magnitude m with
// m^2*norm_a*norm_b <= dot^2*2^30; no input is taken until that result
// is ready. A finished result sits in an output register, so the block
// goes back to accepting pairs as soon as that register is free or being
// drained. A zero norm gives 0 with zero_norm set; pairs beyond the
// 4096th are dropped and flag length_overflow on the result.

module vector_cosine_similarity
  import vcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        in_tlast,   // last pair of the vectors
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] cosine_value
  output logic [1:0]  out_tuser   // [0] zero_norm, [1] length_overflow
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_take;
  logic  zero_norm, length_overflow;
  logic [COS_W-1:0] cosine_value;

  // Step counter and program table
  vcs_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .in_tready (in_tready),
    .in_take   (in_take),
    .ctrl      (ctrl)
  );

  // Multiplier, accumulators, search and result register
  vcs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .in_take         (in_take),
    .in_elem_a       ($signed(in_tdata[ELEM_W-1:0])),
    .in_elem_b       ($signed(in_tdata[2*ELEM_W-1:ELEM_W])),
    .in_last         (in_tlast),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .cosine_value    (cosine_value),
    .zero_norm       (zero_norm),
    .length_overflow (length_overflow),
    .stat            (stat)
  );

  // Pack result fields, lowest first
  assign out_tdata = cosine_value;
  assign out_tuser = {length_overflow, zero_norm};

endmodule

@@ rtl/vcs_checker.sv @@
// Port-level checks for vector_cosine_similarity, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module vcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Zero norm always carries a zero value
  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'd0)
    else $error("zero_norm with nonzero value");

  // Stop taking pairs once the last pair is in
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after last pair");

  // A new result appears only at the end of a computation
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while accepting input");

endmodule

bind vector_cosine_similarity vcs_checker u_vcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/vector_cosine_similarity_tb.sv @@
// Self-checking testbench for vector_cosine_similarity: streams element pairs,
// predicts each cosine request in fixed point and checks every result field.
// Depends on vcs_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module vector_cosine_similarity_tb;
  import vcs_pkg::*;

  localparam int          RAND_ITEMS   = 600;       // random pairs after the table
  localparam int unsigned COS_ONE      = 32768;     // 1.0 in Q1.15
  localparam int          HOLD_AT      = 25;        // result count before the long stall
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 100;
  localparam longint      TIMEOUT_NS   = 64'd40_000_000;

  // One expected request on the result side, packed as the ports carry it.
  typedef struct packed {
    logic [15:0] cos;
    logic        zero_norm;
    logic        len_ovf;
  } cos_res_t;

  // One row of the directed part: the pair is sent reps times, tlast only on the
  // final copy. Rows with known set carry the result that must come back.
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [16:0] reps;
    logic        last;
    logic        known;
    logic [15:0] cos;
    logic        zn;
    logic        ovf;
  } dir_row_t;

  typedef enum logic [1:0] {MIX_FULL, MIX_SMALL, MIX_PARALLEL, MIX_SPARSE} mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] elem_a, [31:16] elem_b
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] cosine_value
  logic [1:0]  out_tuser;       // [0] zero_norm, [1] length_overflow

  // Predictor state, cleared after every vector end.
  logic [DOT_W-1:0]  dot_sum = '0;
  logic [NORM_W-1:0] norm_a_sum = '0;
  logic [NORM_W-1:0] norm_b_sum = '0;
  int unsigned       pairs_seen = 0;

  cos_res_t pending_cosines[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt = 0;
  bit       steady = 1'b0;      // both sides run without gaps while set

  vector_cosine_similarity uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** vector_cosine_similarity: FAILED **");
    $finish;
  end

  // Largest m in [0, 1.0] with m^2 * na * nb <= dot^2 * 2^30, signed and clamped.
  function automatic logic [15:0] cosine_q15(input logic [DOT_W-1:0] dot,
                                             input logic [NORM_W-1:0] na,
                                             input logic [NORM_W-1:0] nb);
    logic [DOT_W:0] dmag;
    logic [127:0]   bound;
    logic [127:0]   trial;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    dmag = {1'b0, dot};
    if (dot[DOT_W-1])
      dmag = {1'b1, {DOT_W{1'b0}}} - dmag;
    bound = 128'(dmag);
    bound = (bound * bound) << 30;
    lo = 0;
    hi = COS_ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      trial = 128'(mid) * 128'(mid) * 128'(na) * 128'(nb);
      if (trial <= bound)
        lo = mid;
      else
        hi = mid - 1;
    end
    if (dot[DOT_W-1])
      return 16'(-lo);
    return (lo > 32767) ? 16'h7FFF : 16'(lo);
  endfunction

  // Fold one accepted pair into the sums; on the vector end, form the result
  // and clear the sums.
  task automatic accumulate_pair(input logic [15:0] a, input logic [15:0] b,
                                 input logic last, output bit has_res,
                                 output cos_res_t res);
    logic signed [31:0] ab;
    logic signed [31:0] aa;
    logic signed [31:0] bb;
    ab = $signed(a) * $signed(b);
    aa = $signed(a) * $signed(a);
    bb = $signed(b) * $signed(b);
    if (pairs_seen < MAX_LEN) begin
      dot_sum    = dot_sum + {{(DOT_W-32){ab[31]}}, ab};
      norm_a_sum = norm_a_sum + {{(NORM_W-32){1'b0}}, aa};
      norm_b_sum = norm_b_sum + {{(NORM_W-32){1'b0}}, bb};
      pairs_seen++;
    end else begin
      // drop the pair, keep the count pinned one past the limit
      pairs_seen = MAX_LEN + 1;
    end
    has_res = last;
    res = '0;
    if (last) begin
      res.len_ovf   = (pairs_seen > MAX_LEN);
      res.zero_norm = (norm_a_sum == 0) || (norm_b_sum == 0);
      if (!res.zero_norm)
        res.cos = cosine_q15(dot_sum, norm_a_sum, norm_b_sum);
      dot_sum    = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      pairs_seen = 0;
    end
  endtask

  // Offer one pair, hold it until accepted, then queue what it should return.
  // Each call returns in the time step of its handshake, so a gap-free next
  // pair leaves in_tvalid high with a single assignment.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                           input logic last, input logic known,
                           input cos_res_t typed_res);
    int       gap;
    bit       has_res;
    cos_res_t pred;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accumulate_pair(a, b, last, has_res, pred);
    if (has_res)
      pending_cosines.push_back(known ? typed_res : pred);
  endtask

  // Result side: unless steady, drop out_tready at random before each request;
  // once, for a long stretch, so the output register fills and the block stops taking pairs.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    forever begin
      if (taken == HOLD_AT)
        stall = HOLD_CYCLES;
      else
        stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Compare every accepted result against the oldest pending request.
  always @(posedge clk) begin : result_check
    cos_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cosines.size() == 0) begin
        $error("unexpected result: cosine_value %0d zero_norm %0b length_overflow %0b",
               $signed(out_tdata), out_tuser[0], out_tuser[1]);
        mismatch_cnt++;
      end else begin
        want = pending_cosines.pop_front();
        if (out_tdata !== want.cos) begin
          $error("cosine_value: expected %0d, got %0d", $signed(want.cos),
                 $signed(out_tdata));
          mismatch_cnt++;
        end
        if (out_tuser[0] !== want.zero_norm) begin
          $error("zero_norm: expected %0b, got %0b", want.zero_norm, out_tuser[0]);
          mismatch_cnt++;
        end
        if (out_tuser[1] !== want.len_ovf) begin
          $error("length_overflow: expected %0b, got %0b", want.len_ovf, out_tuser[1]);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    mix_t     mix;
    int       rand_items;
    int       vec_len;
    bit       flip;
    logic [15:0] ea;
    logic [15:0] eb;

    // a, b, reps, last, known, cos, zero_norm, length_overflow
    dir_rows = '{
      // equal vectors give +1.0, which saturates; opposite ones give -1.0
      '{16'h0100, 16'h0100, 17'd1, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
      '{16'h0100, 16'hFF00, 17'd1, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0},
      // zero norm on either side, or both
      '{16'h0000, 16'h0005, 17'd1, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{16'h0007, 16'h0000, 17'd1, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
      '{16'h0000, 16'h0000, 17'd1, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
      // element extremes
      '{16'h7FFF, 16'h7FFF, 17'd1, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
      '{16'h8000, 16'h8000, 17'd1, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
      '{16'h7FFF, 16'h8000, 17'd1, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0},
      // orthogonal vectors
      '{16'h0001, 16'h0000, 17'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0000, 16'h0001, 17'd1, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0},
      // mixed signs, predicted
      '{16'h0003, 16'h0005, 17'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hFFF9, 16'h0002, 17'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0064, 16'hFED4, 17'd1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h5555, 16'hAAAA, 17'd1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'hAAAA, 16'h5555, 17'd1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
      // exactly the longest vector the block accumulates
      '{16'h0100, 16'h0080, 17'(MAX_LEN), 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
      // too many pairs: the opposite tail is dropped, the flag comes up
      '{16'h0100, 16'h0100, 17'(MAX_LEN), 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h0100, 16'hFF00, 17'd3, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b1},
      // sums clear after an overflowed vector
      '{16'h0002, 16'hFFFD, 17'd1, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0},
      // zero norm and overflow together
      '{16'h0000, 16'h0000, 17'(MAX_LEN + 1), 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1},
      '{16'h0001, 16'h0001, 17'd1, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0},
      '{16'h0123, 16'h0456, 17'd2, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{16'h8000, 16'h7FFF, 17'd1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 1; k <= int'(row.reps); k++)
        send_pair(row.a, row.b, row.last && (k == int'(row.reps)), row.known,
                  cos_res_t'{row.cos, row.zn, row.ovf});
    end

    // Random vectors: mostly short, now and then a longer one, with content
    // ranging from full-scale noise to near-parallel pairs and sparse zeros.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      steady  = ($urandom_range(0, 4) == 0);
      mix     = mix_t'($urandom_range(0, 3));
      flip    = $urandom_range(0, 1);
      vec_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                             : $urandom_range(1, 8);
      for (int i = 0; i < vec_len; i++) begin
        case (mix)
          MIX_FULL: begin
            ea = 16'($urandom);
            eb = 16'($urandom);
          end
          MIX_SMALL: begin
            ea = 16'($urandom_range(0, 64)) - 16'd32;
            eb = 16'($urandom_range(0, 64)) - 16'd32;
          end
          MIX_PARALLEL: begin
            // drive the quotient toward +/-1.0 and its saturation
            ea = 16'($urandom);
            eb = (flip ? -ea : ea) + 16'($urandom_range(0, 2)) - 16'd1;
          end
          default: begin
            ea = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
            eb = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
          end
        endcase
        send_pair(ea, eb, i == vec_len - 1, 1'b0, '0);
        rand_items++;
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // Drain the pending requests, then watch for stray results.
    while (pending_cosines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("** vector_cosine_similarity: PASSED **");
    else
      $display("** vector_cosine_similarity: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/vcs_pkg.sv
rtl/vcs_sequencer.sv
rtl/vcs_datapath.sv
rtl/vector_cosine_similarity.sv
rtl/vcs_checker.sv
tb/vector_cosine_similarity_tb.sv
